@@ rtl/wsd_pkg.sv @@
// package for the websocket frame deframer
// shared constants, the result beat struct and tdata packing widths; no dependencies
`default_nettype none

package wsd_pkg;

    // width of the kept payload length; upper bytes of a 64-bit length fall away
    localparam int LENGTH_BITS = 32;

    // header field masks and the 7-bit length escape codes
    localparam logic [7:0] OPCODE_MASK = 8'h0f;
    localparam logic [7:0] MASK_BIT    = 8'h80;
    localparam logic [7:0] LEN7_MASK   = 8'h7f;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;

    // byte counts of the extended length and masking key fields
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // master tdata: payload_byte and frame_opcode, padded to whole bytes
    localparam int OUT_TDATA_W = 16;

    // one result beat
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       last_of_frame;
        logic       empty_frame;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/wsd_parser.sv @@
// frame header parser and payload unmasking, one byte per accepted beat
// depends on wsd_pkg
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire logic [7:0] i_byte,
    output logic         o_res_valid,
    output t_result      o_res
);

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    t_phase                 r_phase,        n_phase;
    logic [3:0]             r_opcode,       n_opcode;
    logic                   r_mask,         n_mask;
    logic [3:0]             r_hdr_left,     n_hdr_left;
    logic [31:0]            r_key,          n_key;
    logic [LENGTH_BITS-1:0] r_pay_left,     n_pay_left;
    logic [1:0]             r_key_pos,      n_key_pos;

    logic [6:0]             len7;
    logic [7:0]             key_byte;
    logic [7:0]             masked;

    assign len7 = i_byte[6:0] & LEN7_MASK[6:0];

    // key byte for this payload index, first key byte first
    always_comb begin
        case (r_key_pos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    assign masked = r_mask ? (i_byte ^ key_byte) : i_byte;

    // next state and result for the current byte
    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_mask      = r_mask;
        n_hdr_left  = r_hdr_left;
        n_key       = r_key;
        n_pay_left  = r_pay_left;
        n_key_pos   = r_key_pos;
        o_res_valid = 1'b0;
        o_res.payload_byte  = 8'd0;
        o_res.frame_opcode  = r_opcode;
        o_res.last_of_frame = 1'b1;
        o_res.empty_frame   = 1'b1;

        case (r_phase)
            PH_SECOND: begin
                n_mask = (i_byte & MASK_BIT) != 8'd0;
                if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                    n_pay_left = '0;
                    n_hdr_left = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    n_phase    = PH_EXTLEN;
                end else begin
                    n_pay_left = {{(LENGTH_BITS-7){1'b0}}, len7};
                    if (n_mask) begin
                        n_hdr_left = KEY_BYTES;
                        n_phase    = PH_KEY;
                    end else begin
                        n_key_pos = 2'd0;
                        if (len7 == 7'd0) begin
                            n_phase     = PH_FIRST;
                            o_res_valid = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
            end

            PH_EXTLEN: begin
                n_pay_left = {r_pay_left[LENGTH_BITS-9:0], i_byte};
                n_hdr_left = r_hdr_left - 4'd1;
                if (n_hdr_left == 4'd0) begin
                    if (r_mask) begin
                        n_hdr_left = KEY_BYTES;
                        n_phase    = PH_KEY;
                    end else begin
                        n_key_pos = 2'd0;
                        if (n_pay_left == '0) begin
                            n_phase     = PH_FIRST;
                            o_res_valid = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
            end

            PH_KEY: begin
                n_key      = {r_key[23:0], i_byte};
                n_hdr_left = r_hdr_left - 4'd1;
                if (n_hdr_left == 4'd0) begin
                    n_key_pos = 2'd0;
                    if (r_pay_left == '0) begin
                        n_phase     = PH_FIRST;
                        o_res_valid = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end

            PH_PAYLOAD: begin
                n_key_pos   = r_key_pos + 2'd1;
                n_pay_left  = r_pay_left - LENGTH_BITS'(1);
                o_res_valid = 1'b1;
                o_res.payload_byte  = masked;
                o_res.empty_frame   = 1'b0;
                o_res.last_of_frame = (n_pay_left == '0);
                if (n_pay_left == '0) begin
                    n_phase = PH_FIRST;
                end
            end

            default: begin
                n_opcode = i_byte[3:0] & OPCODE_MASK[3:0];
                n_phase  = PH_SECOND;
            end
        endcase
    end

    // parser state, advanced on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_opcode   <= 4'd0;
            r_mask     <= 1'b0;
            r_hdr_left <= 4'd0;
            r_key      <= 32'd0;
            r_pay_left <= '0;
            r_key_pos  <= 2'd0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_opcode   <= n_opcode;
            r_mask     <= n_mask;
            r_hdr_left <= n_hdr_left;
            r_key      <= n_key;
            r_pay_left <= n_pay_left;
            r_key_pos  <= n_key_pos;
        end
    end

endmodule

`default_nettype wire

@@ rtl/wsd_out_skid.sv @@
// result register with a skid entry so the input ready is registered
// depends on wsd_pkg
`default_nettype none

module wsd_out_skid
    import wsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_pop_ready,
    output t_result      o_res
);

    logic    r_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_res   = r_main;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_valid || pop) begin
                r_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_valid || pop) begin
                r_main <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/websocket_frame_deframer.sv @@
// top level of the websocket frame deframer
// depends on wsd_pkg, wsd_parser and wsd_out_skid
`default_nettype none

// Receive-side WebSocket (RFC 6455) frame deframer. Takes the frame stream one
// byte per beat and returns unmasked payload bytes tagged with the frame opcode,
// tlast on the final byte and tuser set for a zero-length frame, which yields a
// single empty beat. One byte is taken every cycle while s_axis_tready is high;
// the only loop is the parser state register. Results are registered, in the
// skid entry while the output register is full; the skid keeps s_axis_tready
// registered and high while one result waits. FIN and RSV bits are ignored, the
// opcode passes through unchecked, and only the low LENGTH_BITS bits of an
// extended length are kept. No initialization pass after reset.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] stream_byte
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_opcode
    output logic                        m_axis_tlast,   // last_of_frame
    output logic                        m_axis_tuser    // empty_frame
);

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    // header parsing and unmasking
    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register and skid entry
    wsd_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept && res_valid),
        .i_res       (res),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_res       (out_res)
    );

    // beat packing
    assign m_axis_tdata = {{(OUT_TDATA_W-12){1'b0}}, out_res.frame_opcode, out_res.payload_byte};
    assign m_axis_tlast = out_res.last_of_frame;
    assign m_axis_tuser = out_res.empty_frame;

endmodule

`default_nettype wire
